// ===== rtl/complex_matrix_vector_multiply_macros.svh =====
// Assertion macros for the complex matrix-vector multiplier.
// Included by the top level; no other dependencies.
`ifndef COMPLEX_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define COMPLEX_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`ifndef SYNTHESIS
`define CMVM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmvm assertion failed");
`define CMVM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmvm assertion failed");
`else
`define CMVM_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CMVM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cmvm_pkg.sv =====
// Shared types and constants for the complex matrix-vector multiplier.
// No dependencies.
package cmvm_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0]  CSR_DIM     = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_ADJOINT = 1'b1;
   localparam logic [CSR_DATA_W-1:0] DIM_RESET   = 5'd16;

   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_MATRIX,
      CMD_VECTOR,
      CMD_START
   } cmd_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic valid;
      logic row_first;
      logic row_end;
      logic prod_last;
      logic adj;
   } ctl_type;

endpackage

// ===== rtl/cmvm_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module cmvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cmvm_fifo.sv =====
// Small flop-based FIFO with occupancy count.
// No dependencies.
module cmvm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full,
   output logic [CW-1:0]    count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (32'(count_ff) == DEPTH);
   assign count   = count_ff;
   assign rdata   = mem_ff[head_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (do_pop) begin
         head_in = (32'(head_ff) == DEPTH - 1) ? '0 : head_ff + PW'(1);
      end
      if (do_push) begin
         tail_in = (32'(tail_ff) == DEPTH - 1) ? '0 : tail_ff + PW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/cmvm_front.sv =====
// Front end: accepts input items, drops out-of-range writes, classifies the
// rest and queues them as commands. Depends on cmvm_pkg and cmvm_fifo.
module cmvm_front #(
   parameter int MAX_DIM      = 16,
   parameter int SAMPLE_WIDTH = 16,
   localparam int IW = $clog2(MAX_DIM)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         action,
   input  logic [IW-1:0]                row,
   input  logic [IW-1:0]                column,
   input  logic [SAMPLE_WIDTH-1:0]      value_re,
   input  logic [SAMPLE_WIDTH-1:0]      value_im,
   input  logic                         last,
   input  logic                         cmd_pop,
   output logic                         cmd_empty,
   output cmvm_pkg::cmd_kind_type       cmd_kind,
   output logic [IW-1:0]                cmd_row,
   output logic [IW-1:0]                cmd_col,
   output logic [SAMPLE_WIDTH-1:0]      cmd_re,
   output logic [SAMPLE_WIDTH-1:0]      cmd_im
);

   import cmvm_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int KW = $bits(cmd_kind_type);
   localparam int CMD_W = KW + 2 * IW + 2 * SW;

   cmd_kind_type     kind;
   logic             keep;
   logic             row_ok, col_ok;
   logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

   assign row_ok = (32'(row) < MAX_DIM);
   assign col_ok = (32'(column) < MAX_DIM);

   always_comb begin
      if (!action) begin
         kind = CMD_MATRIX;
         keep = row_ok && col_ok;
      end else begin
         kind = last ? CMD_START : CMD_VECTOR;
         keep = col_ok;
      end
   end

   assign cmd_wdata = {kind, row, column, value_re, value_im};

   cmvm_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock(clock),
      .reset(reset),
      .push (push && keep),
      .wdata(cmd_wdata),
      .pop  (cmd_pop),
      .rdata(cmd_rdata),
      .empty(cmd_empty),
      .full (full),
      .count()
   );

   assign cmd_kind = cmd_kind_type'(cmd_rdata[CMD_W-1 -: KW]);
   assign cmd_row  = cmd_rdata[2*IW+2*SW-1 -: IW];
   assign cmd_col  = cmd_rdata[IW+2*SW-1 -: IW];
   assign cmd_re   = cmd_rdata[2*SW-1 -: SW];
   assign cmd_im   = cmd_rdata[SW-1:0];

endmodule

// ===== rtl/cmvm_back.sv =====
// Back end: matrix and vector stores, row/column sequencer, MAC pipeline,
// rounding, saturation and result queue. Depends on cmvm_pkg, cmvm_ram, cmvm_fifo.
module cmvm_back #(
   parameter int MAX_DIM      = 16,
   parameter int SAMPLE_WIDTH = 16,
   localparam int IW    = $clog2(MAX_DIM),
   localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_empty,
   output logic                         cmd_pop,
   input  cmvm_pkg::cmd_kind_type       cmd_kind,
   input  logic [IW-1:0]                cmd_row,
   input  logic [IW-1:0]                cmd_col,
   input  logic [SAMPLE_WIDTH-1:0]      cmd_re,
   input  logic [SAMPLE_WIDTH-1:0]      cmd_im,
   input  logic [DIM_W-1:0]             d_active,
   input  logic                         adjoint,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [IW-1:0]                rsp_index,
   output logic [SAMPLE_WIDTH-1:0]      rsp_re,
   output logic [SAMPLE_WIDTH-1:0]      rsp_im,
   output logic                         rsp_sat,
   output logic                         rsp_last
);

   import cmvm_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int PW     = 2 * SW;
   localparam int TW     = 2 * SW + 1;
   localparam int ACC_W  = 2 * SW + $clog2(MAX_DIM) + 2;
   localparam int QW     = ACC_W - SW + 1;
   localparam int MAW    = 2 * IW;
   localparam int MDEPTH = 1 << MAW;
   localparam int OW     = IW + 2 * SW + 2;
   localparam int OCW    = $clog2(OUT_DEPTH + 1);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (SW - 2);
   localparam logic signed [QW-1:0]    QMAX = QW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [QW-1:0]    QMIN = ~QMAX;

   state_type   state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic        adj_ff, adj_in;
   logic        issue, mat_we, vec_we, start;
   logic        row_end, prod_last, credit_ok;
   logic [OCW-1:0] inflight_ff, inflight_in, out_count;
   logic [MAW-1:0] mat_raddr;
   logic [PW-1:0]  mat_rdata, vec_rdata;

   ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   logic [IW-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff;

   logic signed [SW-1:0] m_re, m_im, v_re, v_im;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [TW-1:0] t_re_ff, t_im_ff, t_re_in, t_im_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [ACC_W-1:0] sum_re, sum_im;
   logic signed [QW-1:0] q_re_ff, q_im_ff;
   logic [SW-1:0] y_re, y_im;
   logic          sat_re, sat_im;
   logic          out_push;
   logic [OW-1:0] out_wdata, out_rdata;

   assign row_end   = ((DIM_W'(j_ff) + DIM_W'(1)) == d_active);
   assign prod_last = ((DIM_W'(i_ff) + DIM_W'(1)) == d_active);
   assign credit_ok = ((OCW + 1)'(inflight_ff) + (OCW + 1)'(out_count))
                      < (OCW + 1)'(OUT_DEPTH);
   assign start     = cmd_pop && (cmd_kind == CMD_START);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue && row_end && prod_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop = 1'b0;
      issue   = 1'b0;
      case (state_ff)
         ST_IDLE: cmd_pop = !cmd_empty;
         ST_RUN:  issue   = (j_ff != '0) || credit_ok;
         default: begin
            cmd_pop = 1'b0;
            issue   = 1'b0;
         end
      endcase
   end

   assign mat_we = cmd_pop && (cmd_kind == CMD_MATRIX);
   assign vec_we = cmd_pop && (cmd_kind != CMD_MATRIX);

   always_comb begin
      i_in   = i_ff;
      j_in   = j_ff;
      adj_in = adj_ff;
      if (start) begin
         i_in   = '0;
         j_in   = '0;
         adj_in = adjoint;
      end else if (issue) begin
         if (row_end) begin
            j_in = '0;
            i_in = i_ff + IW'(1);
         end else begin
            j_in = j_ff + IW'(1);
         end
      end
   end

   assign inflight_in = inflight_ff + OCW'(issue && (j_ff == '0)) - OCW'(out_push);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         i_ff        <= '0;
         j_ff        <= '0;
         adj_ff      <= 1'b0;
         inflight_ff <= '0;
         ctl1_ff     <= '0;
         ctl2_ff     <= '0;
         ctl3_ff     <= '0;
         ctl4_ff     <= '0;
         ctl5_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         adj_ff      <= adj_in;
         inflight_ff <= inflight_in;
         ctl1_ff     <= '{valid: issue, row_first: (j_ff == '0), row_end: row_end,
                          prod_last: prod_last, adj: adj_ff};
         ctl2_ff     <= ctl1_ff;
         ctl3_ff     <= ctl2_ff;
         ctl4_ff     <= '{valid: ctl3_ff.valid && ctl3_ff.row_end,
                          row_first: ctl3_ff.row_first, row_end: ctl3_ff.row_end,
                          prod_last: ctl3_ff.prod_last, adj: ctl3_ff.adj};
         ctl5_ff     <= ctl4_ff;
      end
   end

   assign mat_raddr = adj_ff ? {j_ff, i_ff} : {i_ff, j_ff};

   cmvm_ram #(
      .WIDTH(PW),
      .DEPTH(MDEPTH)
   ) u_mat_ram (
      .clock(clock),
      .we   (mat_we),
      .waddr({cmd_row, cmd_col}),
      .wdata({cmd_re, cmd_im}),
      .raddr(mat_raddr),
      .rdata(mat_rdata)
   );

   cmvm_ram #(
      .WIDTH(PW),
      .DEPTH(MAX_DIM)
   ) u_vec_ram (
      .clock(clock),
      .we   (vec_we),
      .waddr(cmd_col),
      .wdata({cmd_re, cmd_im}),
      .raddr(j_ff),
      .rdata(vec_rdata)
   );

   assign m_re = $signed(mat_rdata[PW-1:SW]);
   assign m_im = $signed(mat_rdata[SW-1:0]);
   assign v_re = $signed(vec_rdata[PW-1:SW]);
   assign v_im = $signed(vec_rdata[SW-1:0]);

   // conjugate transpose flips the sign of the matrix imaginary part
   always_comb begin
      if (ctl2_ff.adj) begin
         t_re_in = TW'(p_rr_ff) + TW'(p_ii_ff);
         t_im_in = TW'(p_ri_ff) - TW'(p_ir_ff);
      end else begin
         t_re_in = TW'(p_rr_ff) - TW'(p_ii_ff);
         t_im_in = TW'(p_ri_ff) + TW'(p_ir_ff);
      end
      acc_re_in = (ctl3_ff.row_first ? ACC_W'(0) : acc_re_ff) + ACC_W'(t_re_ff);
      acc_im_in = (ctl3_ff.row_first ? ACC_W'(0) : acc_im_ff) + ACC_W'(t_im_ff);
   end

   // round half up, then floor shift
   assign sum_re = acc_re_ff + HALF;
   assign sum_im = acc_im_ff + HALF;

   always_ff @(posedge clock) begin
      idx1_ff <= i_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      idx5_ff <= idx4_ff;
      p_rr_ff <= m_re * v_re;
      p_ii_ff <= m_im * v_im;
      p_ri_ff <= m_re * v_im;
      p_ir_ff <= m_im * v_re;
      t_re_ff <= t_re_in;
      t_im_ff <= t_im_in;
      if (ctl3_ff.valid) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      q_re_ff <= QW'(sum_re >>> (SW - 1));
      q_im_ff <= QW'(sum_im >>> (SW - 1));
   end

   always_comb begin
      sat_re = (q_re_ff > QMAX) || (q_re_ff < QMIN);
      sat_im = (q_im_ff > QMAX) || (q_im_ff < QMIN);
      if (q_re_ff > QMAX) begin
         y_re = SW'(QMAX);
      end else if (q_re_ff < QMIN) begin
         y_re = SW'(QMIN);
      end else begin
         y_re = SW'(q_re_ff);
      end
      if (q_im_ff > QMAX) begin
         y_im = SW'(QMAX);
      end else if (q_im_ff < QMIN) begin
         y_im = SW'(QMIN);
      end else begin
         y_im = SW'(q_im_ff);
      end
   end

   assign out_push  = ctl5_ff.valid;
   assign out_wdata = {idx5_ff, y_re, y_im, sat_re || sat_im, ctl5_ff.prod_last};

   cmvm_fifo #(
      .WIDTH(OW),
      .DEPTH(OUT_DEPTH)
   ) u_out_fifo (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .wdata(out_wdata),
      .pop  (rsp_pop),
      .rdata(out_rdata),
      .empty(rsp_empty),
      .full (),
      .count(out_count)
   );

   assign rsp_index = out_rdata[OW-1 -: IW];
   assign rsp_re    = out_rdata[2*SW+1 -: SW];
   assign rsp_im    = out_rdata[SW+1 -: SW];
   assign rsp_sat   = out_rdata[1];
   assign rsp_last  = out_rdata[0];

endmodule

// ===== rtl/complex_matrix_vector_multiply.sv =====
// Complex matrix-vector multiplier (M*x or M^H*x), top level; uses cmvm_pkg,
// cmvm_front, cmvm_back and the assertion macro header.
// Back end: takes matrix and vector writes only while idle; a starting vector write runs
//   the product at one complex MAC per cycle (a row waits while four rows are pending).
// Synchronous active-high reset: dim = 16, adjoint off, queues empty; stores keep data.
module complex_matrix_vector_multiply #(
   parameter int MAX_DIM      = 16,
   parameter int SAMPLE_WIDTH = 16,
   localparam int IW = $clog2(MAX_DIM)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_action,
   input  logic [IW-1:0]                   req_row,
   input  logic [IW-1:0]                   req_column,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_value_re,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_value_im,
   input  logic                            req_last,
   output logic                            empty,
   input  logic                            pop,
   output logic [IW-1:0]                   rsp_out_index,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_out_re,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_out_im,
   output logic                            rsp_saturated,
   output logic                            rsp_out_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cmvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cmvm_pkg::CSR_DATA_W-1:0] csr_data
);

   import cmvm_pkg::*;

`include "complex_matrix_vector_multiply_macros.svh"

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [CSR_DATA_W-1:0]   dim_ff;
   logic                    adj_ff;
   logic [DIM_W-1:0]        d_active;
   logic                    cmd_pop, cmd_empty;
   cmd_kind_type            cmd_kind;
   logic [IW-1:0]           cmd_row, cmd_col;
   logic [SAMPLE_WIDTH-1:0] cmd_re, cmd_im;
   logic [SAMPLE_WIDTH-1:0] rsp_re, rsp_im;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
         adj_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIM:     dim_ff <= csr_data;
            CSR_ADJOINT: adj_ff <= csr_data[0];
            default:     dim_ff <= dim_ff;
         endcase
      end
   end

   always_comb begin
      if (dim_ff == '0) begin
         d_active = DIM_W'(1);
      end else if (32'(dim_ff) > MAX_DIM) begin
         d_active = DIM_W'(MAX_DIM);
      end else begin
         d_active = DIM_W'(dim_ff);
      end
   end

   cmvm_front #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .action   (req_action),
      .row      (req_row),
      .column   (req_column),
      .value_re (req_value_re),
      .value_im (req_value_im),
      .last     (req_last),
      .cmd_pop  (cmd_pop),
      .cmd_empty(cmd_empty),
      .cmd_kind (cmd_kind),
      .cmd_row  (cmd_row),
      .cmd_col  (cmd_col),
      .cmd_re   (cmd_re),
      .cmd_im   (cmd_im)
   );

   cmvm_back #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .cmd_kind (cmd_kind),
      .cmd_row  (cmd_row),
      .cmd_col  (cmd_col),
      .cmd_re   (cmd_re),
      .cmd_im   (cmd_im),
      .d_active (d_active),
      .adjoint  (adj_ff),
      .rsp_pop  (pop),
      .rsp_empty(empty),
      .rsp_index(rsp_out_index),
      .rsp_re   (rsp_re),
      .rsp_im   (rsp_im),
      .rsp_sat  (rsp_saturated),
      .rsp_last (rsp_out_last)
   );

   assign rsp_out_re = $signed(rsp_re);
   assign rsp_out_im = $signed(rsp_im);

   `CMVM_ASSERT_IMPL(a_dim_range, clock, reset, 1'b1, (d_active != '0) && (32'(d_active) <= MAX_DIM))
   `CMVM_ASSERT_IMPL(a_last_index, clock, reset, !empty && rsp_out_last, (32'(rsp_out_index) + 1) == 32'(d_active))
   `CMVM_ASSERT_NEXT(a_dim_write, clock, reset, csr_valid && csr_ready && (csr_index == CSR_DIM), dim_ff == $past(csr_data))

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the complex matrix-vector multiplier (M*x and M^H*x).
// Drives matrix and vector writes through the push/full queue and checks every result
// element against an internal predictor. Depends on cmvm_pkg and the RTL top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cmvm_pkg::*;

   localparam int     N               = 16;
   localparam logic   WR_MATRIX       = 1'b0;
   localparam logic   WR_VECTOR       = 1'b1;
   localparam int     RANDOM_ITEMS    = 215;
   localparam int     BIG_DIM_BUDGET  = 110;
   localparam int     HOLD_OFF_CYCLES = 500;
   localparam int     DRAIN_CYCLES    = 40;
   localparam longint CYCLE_LIMIT     = 300000;

   typedef struct packed {
      logic               action;
      logic [3:0]         row;
      logic [3:0]         column;
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               last;
   } write_type;

   typedef struct packed {
      logic [3:0]         index;
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               sat;
      logic               last;
   } element_type;

   class product_scoreboard;
      bit signed [15:0] m_re [N*N];
      bit signed [15:0] m_im [N*N];
      bit signed [15:0] v_re [N];
      bit signed [15:0] v_im [N];
      logic [CSR_DATA_W-1:0] dim_reg = DIM_RESET;
      logic adjoint = 1'b0;
      element_type expected_elements[$];
      int failures = 0;
      int reported = 0;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DIM) begin
            dim_reg = data;
         end else if (idx == CSR_ADJOINT) begin
            adjoint = data[0];
         end
      endfunction

      function logic signed [15:0] round_clip(longint acc, inout bit sat);
         longint q;
         q = (acc + 64'sd16384) >>> 15;
         if (q > 32767) begin
            sat = 1'b1;
            return 16'sh7fff;
         end
         if (q < -32768) begin
            sat = 1'b1;
            return 16'sh8000;
         end
         return 16'(q);
      endfunction

      // Called for every accepted transaction, in acceptance order.
      function void note_write(write_type w);
         int d, i, j;
         longint acc_re, acc_im, ar, ai, br, bi;
         bit sat;
         element_type e;
         if (w.action == WR_MATRIX) begin
            m_re[w.row * N + w.column] = w.re;
            m_im[w.row * N + w.column] = w.im;
            return;
         end
         v_re[w.column] = w.re;
         v_im[w.column] = w.im;
         if (!w.last) return;
         d = (dim_reg == 0) ? 1 : (dim_reg > N) ? N : int'(dim_reg);
         for (i = 0; i < d; i++) begin
            acc_re = 0;
            acc_im = 0;
            sat = 1'b0;
            for (j = 0; j < d; j++) begin
               br = v_re[j];
               bi = v_im[j];
               if (!adjoint) begin
                  ar = m_re[i * N + j];
                  ai = m_im[i * N + j];
               end else begin
                  ar = m_re[j * N + i];
                  ai = m_im[j * N + i];
                  ai = -ai;
               end
               acc_re += ar * br - ai * bi;
               acc_im += ar * bi + ai * br;
            end
            e.index = 4'(i);
            e.re    = round_clip(acc_re, sat);
            e.im    = round_clip(acc_im, sat);
            e.sat   = sat;
            e.last  = (i == d - 1);
            expected_elements.push_back(e);
         end
      endfunction

      function void check_element(element_type got);
         element_type want;
         if (expected_elements.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result: index %0d re %0d im %0d sat %0b last %0b",
                        got.index, got.re, got.im, got.sat, got.last);
            end
            return;
         end
         want = expected_elements.pop_front();
         if (got !== want) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected index %0d re %0d im %0d sat %0b last %0b",
                        want.index, want.re, want.im, want.sat, want.last);
               $display("          actual   index %0d re %0d im %0d sat %0b last %0b",
                        got.index, got.re, got.im, got.sat, got.last);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic                  req_action = 1'b0;
   logic [3:0]            req_row = '0;
   logic [3:0]            req_column = '0;
   logic signed [15:0]    req_value_re = '0;
   logic signed [15:0]    req_value_im = '0;
   logic                  req_last = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [3:0]            rsp_out_index;
   logic signed [15:0]    rsp_out_re;
   logic signed [15:0]    rsp_out_im;
   logic                  rsp_saturated;
   logic                  rsp_out_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   product_scoreboard scoreboard = new;
   bit     matrix_loaded [N][N];
   bit     vector_loaded [N];
   int     items_sent = 0;
   int     burst_left = 0;
   bit     hold_off_go = 1'b0;
   longint cycle_count = 0;

   complex_matrix_vector_multiply i_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_action    (req_action),
      .req_row       (req_row),
      .req_column    (req_column),
      .req_value_re  (req_value_re),
      .req_value_im  (req_value_im),
      .req_last      (req_last),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_index (rsp_out_index),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im),
      .rsp_saturated (rsp_saturated),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // One transaction; push stays high across a burst.
   task automatic offer(logic action, logic [3:0] row, logic [3:0] column,
                        logic signed [15:0] re, logic signed [15:0] im, logic last);
      write_type w;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      w.action = action;
      w.row    = row;
      w.column = column;
      w.re     = re;
      w.im     = im;
      w.last   = last;
      req_action   <= action;
      req_row      <= row;
      req_column   <= column;
      req_value_re <= re;
      req_value_im <= im;
      req_last     <= last;
      push         <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      scoreboard.note_write(w);
      items_sent++;
      if (action == WR_MATRIX) begin
         matrix_loaded[row][column] = 1'b1;
      end else begin
         vector_loaded[column] = 1'b1;
      end
   endtask

   task automatic settle();
      push <= 1'b0;
      burst_left = 0;
      while (scoreboard.expected_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] dim_value, logic adjoint_value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_DIM;
      csr_data  <= dim_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scoreboard.set_register(CSR_DIM, dim_value);
      csr_index <= CSR_ADJOINT;
      csr_data  <= CSR_DATA_W'(adjoint_value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scoreboard.set_register(CSR_ADJOINT, CSR_DATA_W'(adjoint_value));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 4) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   // Loads whatever the product still needs, adds random rewrites, then starts it.
   task automatic random_product(int d);
      int r, c;
      for (r = 0; r < d; r++) begin
         for (c = 0; c < d; c++) begin
            if (!matrix_loaded[r][c]) begin
               offer(WR_MATRIX, 4'(r), 4'(c), pick_sample(), pick_sample(), 1'($urandom));
            end
         end
      end
      repeat ($urandom_range(0, d + 2)) begin
         offer(WR_MATRIX, 4'($urandom), 4'($urandom), pick_sample(), pick_sample(),
               1'($urandom));
      end
      for (c = 0; c < d; c++) begin
         if (!vector_loaded[c]) begin
            offer(WR_VECTOR, 4'($urandom), 4'(c), pick_sample(), pick_sample(), 1'b0);
         end
      end
      repeat ($urandom_range(0, d)) begin
         offer(WR_VECTOR, 4'($urandom), 4'($urandom), pick_sample(), pick_sample(), 1'b0);
      end
      offer(WR_VECTOR, 4'($urandom), 4'($urandom), pick_sample(), pick_sample(), 1'b1);
   endtask

   initial begin
      int d, directed_count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rounding ties in both directions
      configure(5'd1, 1'b0);
      offer(WR_MATRIX, 4'd0, 4'd0, 16'sh4000, 16'sh0000, 1'b0);
      offer(WR_VECTOR, 4'd9, 4'd0, 16'sh0001, 16'shffff, 1'b1);

      // full-scale values, last on a matrix write, start from an unused vector index
      configure(5'd2, 1'b0);
      offer(WR_MATRIX, 4'd0, 4'd0, 16'sh8000, 16'sh8000, 1'b0);
      offer(WR_MATRIX, 4'd0, 4'd1, 16'sh8000, 16'sh8000, 1'b0);
      offer(WR_MATRIX, 4'd1, 4'd0, 16'sh7fff, 16'sh7fff, 1'b0);
      offer(WR_MATRIX, 4'd1, 4'd1, 16'sh7fff, 16'sh8000, 1'b0);
      offer(WR_MATRIX, 4'd15, 4'd15, 16'sh7fff, 16'sh8000, 1'b1);
      offer(WR_VECTOR, 4'd0, 4'd0, 16'sh8000, 16'sh8000, 1'b0);
      offer(WR_VECTOR, 4'd3, 4'd1, 16'sh8000, 16'sh8000, 1'b0);
      offer(WR_VECTOR, 4'd15, 4'd15, 16'sh7fff, 16'sh7fff, 1'b1);

      configure(5'd2, 1'b1);
      offer(WR_VECTOR, 4'd0, 4'd1, 16'sh7fff, 16'sh8000, 1'b1);

      // dim of zero behaves as one
      configure(5'd0, 1'b1);
      offer(WR_VECTOR, 4'd5, 4'd0, 16'sh8000, 16'sh7fff, 1'b1);
      directed_count = items_sent;

      // receiver backs off during this phase so both queues fill up
      configure(5'd4, 1'b0);
      hold_off_go = 1'b1;
      repeat (6) random_product(4);

      while (items_sent < directed_count + RANDOM_ITEMS) begin
         if (($urandom_range(0, 4) == 0) &&
             (items_sent + BIG_DIM_BUDGET < directed_count + RANDOM_ITEMS)) begin
            d = $urandom_range(7, 10);
         end else begin
            d = $urandom_range(1, 6);
         end
         configure(5'(d), 1'($urandom));
         repeat ($urandom_range(2, 5)) begin
            if (items_sent < directed_count + RANDOM_ITEMS) begin
               random_product(d);
            end
         end
      end

      settle();
      if (scoreboard.failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      int hold_left, stretch_left, mode;
      bit hold_done;
      logic [7:0] pop_pattern;
      hold_left = 0;
      stretch_left = 0;
      mode = 0;
      hold_done = 1'b0;
      pop_pattern = 8'h01;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            scoreboard.check_element({rsp_out_index, rsp_out_re, rsp_out_im,
                                      rsp_saturated, rsp_out_last});
         end
         if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               mode = $urandom_range(0, 3);
               stretch_left = $urandom_range(8, 64);
               pop_pattern = 8'($urandom) | 8'h01;
            end
            stretch_left--;
            case (mode)
               0: pop <= 1'b1;
               1: pop <= ($urandom_range(0, 1) == 1);
               2: pop <= ($urandom_range(0, 4) == 0);
               default: begin
                  pop <= pop_pattern[0];
                  pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
               end
            endcase
         end
      end
   end

endmodule
